// ===== rtl/adts_pkg.sv =====
// Shared types and constants for the ADTS deframer.
package adts_pkg;

    localparam int LEN_W = 13;

    // Header layout
    localparam logic [7:0]       SYNC_BYTE   = 8'hFF;
    localparam logic [3:0]       SYNC_NIBBLE = 4'hF;
    localparam logic [LEN_W-1:0] HDR_LEN     = 13'd7;
    localparam logic [2:0]       HDR_IDX_FIRST = 3'd2;
    localparam logic [2:0]       HDR_IDX_LEN_HI = 3'd3;
    localparam logic [2:0]       HDR_IDX_LEN_MID = 3'd4;
    localparam logic [2:0]       HDR_IDX_LEN_LO = 3'd5;
    localparam logic [2:0]       HDR_IDX_LAST = 3'd6;

    // Parser phases
    localparam logic [1:0] PH_HUNT0   = 2'd0;
    localparam logic [1:0] PH_HUNT1   = 2'd1;
    localparam logic [1:0] PH_HEADER  = 2'd2;
    localparam logic [1:0] PH_PAYLOAD = 2'd3;

    // Frame status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_BAD_LEN   = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       buffer_end;
    } in_word_t;

    typedef struct packed {
        logic [7:0]       payload_byte;
        logic             frame_first;
        logic             frame_last;
        logic [LEN_W-1:0] payload_length;
        logic [1:0]       frame_status;
    } out_word_t;

endpackage

// ===== rtl/adts_if.sv =====
// Valid/ready stream interfaces for the deframer's input and output channels.
interface adts_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       buffer_end;

    modport source (output valid, output data_byte, output buffer_end, input ready);
    modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface adts_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  payload_byte;
    logic        frame_first;
    logic        frame_last;
    logic [12:0] payload_length;
    logic [1:0]  frame_status;

    modport source (output valid, output payload_byte, output frame_first,
                    output frame_last, output payload_length, output frame_status,
                    input ready);
    modport sink   (input valid, input payload_byte, input frame_first,
                    input frame_last, input payload_length, input frame_status,
                    output ready);
endinterface

// ===== rtl/adts_aac_deframer.sv =====
// ADTS deframer: takes a raw ADTS byte stream one word per cycle, skips bytes
// until the 12-bit sync is found, reads the 7-byte header and its 13-bit frame
// length, and passes on the payload bytes with first/last marks, the payload
// length and a status (ok, truncated at buffer end, bad length, empty frame).
// Header bytes and skipped bytes give no output word, but for the status word that
// closes a frame cut short, empty or of bad length. The block sustains one input
// word per cycle: each word goes through an input register, the combinational
// parser logic and a result register before its result is offered on the output.
// The input stalls only while both registers hold a word and the downstream side
// does not take the held result in that cycle.
module adts_aac_deframer (
    input logic clk,
    input logic rst_n,
    adts_in_if.sink    stream,
    adts_out_if.source frames
);
    import adts_pkg::*;

    in_word_t  in_word;
    in_word_t  word;
    logic      word_valid;
    logic      take;
    logic      res_valid;
    out_word_t res;
    logic      out_busy;
    out_word_t out_word;

    assign in_word.data_byte  = stream.data_byte;
    assign in_word.buffer_end = stream.buffer_end;

    assign take = word_valid && !out_busy;

    adts_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stream.valid),
        .in_ready   (stream.ready),
        .in_word    (in_word),
        .word_valid (word_valid),
        .word       (word),
        .word_take  (take)
    );

    adts_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .word      (word),
        .res_valid (res_valid),
        .res       (res)
    );

    adts_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && res_valid),
        .load_word (res),
        .busy      (out_busy),
        .out_valid (frames.valid),
        .out_ready (frames.ready),
        .out_word  (out_word)
    );

    assign frames.payload_byte   = out_word.payload_byte;
    assign frames.frame_first    = out_word.frame_first;
    assign frames.frame_last     = out_word.frame_last;
    assign frames.payload_length = out_word.payload_length;
    assign frames.frame_status   = out_word.frame_status;

`ifndef SYNTHESIS
    // Error and empty results always close a frame on their own.
    assert property (@(posedge clk) disable iff (!rst_n)
        frames.valid && (frames.frame_status == ST_BAD_LEN ||
                         frames.frame_status == ST_EMPTY)
        |-> frames.frame_first && frames.frame_last && frames.payload_length == '0)
        else $error("error or empty result without first/last or with a length");

    // A truncation result always ends the frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        frames.valid && frames.frame_status == ST_TRUNCATED |-> frames.frame_last)
        else $error("truncated result without last mark");

    // A word waiting in the input register is never dropped while the output stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        word_valid && out_busy |=> word_valid && $stable(word))
        else $error("input word lost during output stall");

    // The parser only advances when the result register can take its output.
    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> !(frames.valid && !frames.ready))
        else $error("parser advanced while result register was held");
`endif

endmodule

// ===== rtl/adts_in_reg.sv =====
// Input register stage: holds one incoming word until the parser takes it.
module adts_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  adts_pkg::in_word_t in_word,
    output logic              word_valid,
    output adts_pkg::in_word_t word,
    input  logic              word_take
);
    import adts_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;

    assign in_ready   = !valid_reg || word_take;
    assign word_valid = valid_reg;
    assign word       = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (word_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

// ===== rtl/adts_fsm.sv =====
// Header parser: sync hunt, length capture and payload counting, one word per cycle whenever a word is taken.
module adts_fsm (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  adts_pkg::in_word_t word,
    output logic               res_valid,
    output adts_pkg::out_word_t res
);
    import adts_pkg::*;

    logic [1:0]       phase_reg,        phase_next;
    logic [2:0]       header_count_reg, header_count_next;
    logic [LEN_W-1:0] frame_length_reg, frame_length_next;
    logic [LEN_W-1:0] bytes_left_reg,   bytes_left_next;
    logic             first_pending_reg, first_pending_next;

    logic [LEN_W-1:0] len_upd;
    logic [LEN_W-1:0] plen;
    logic [7:0]       b;
    logic             end_flag;

    assign b        = word.data_byte;
    assign end_flag = word.buffer_end;

    // Length field with this header byte merged in.
    always_comb
    begin
        len_upd = frame_length_reg;
        case (header_count_reg)
            HDR_IDX_LEN_HI:  len_upd = {b[1:0], frame_length_reg[10:0]};
            HDR_IDX_LEN_MID: len_upd = {frame_length_reg[12:11], b, frame_length_reg[2:0]};
            HDR_IDX_LEN_LO:  len_upd = {frame_length_reg[12:3], b[7:5]};
            default:         len_upd = frame_length_reg;
        endcase
    end

    assign plen = (frame_length_reg >= HDR_LEN) ? frame_length_reg - HDR_LEN : '0;

    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        frame_length_next  = frame_length_reg;
        bytes_left_next    = bytes_left_reg;
        first_pending_next = first_pending_reg;
        res_valid          = 1'b0;
        res                = '0;

        unique case (phase_reg)
            PH_HUNT0:
            begin
                if (b == SYNC_BYTE && !end_flag)
                begin
                    phase_next = PH_HUNT1;
                end
                else
                begin
                    phase_next        = PH_HUNT0;
                    header_count_next = '0;
                    bytes_left_next   = '0;
                    first_pending_next = 1'b0;
                end
            end
            PH_HUNT1:
            begin
                phase_next         = PH_HUNT0;
                header_count_next  = '0;
                bytes_left_next    = '0;
                first_pending_next = 1'b0;
                if (b[7:4] == SYNC_NIBBLE)
                begin
                    if (end_flag)
                    begin
                        res_valid        = 1'b1;
                        res.frame_first  = 1'b1;
                        res.frame_last   = 1'b1;
                        res.frame_status = ST_TRUNCATED;
                    end
                    else
                    begin
                        phase_next        = PH_HEADER;
                        header_count_next = HDR_IDX_FIRST;
                        frame_length_next = '0;
                    end
                end
            end
            PH_HEADER:
            begin
                frame_length_next = len_upd;
                if (header_count_reg < HDR_IDX_LAST)
                begin
                    if (end_flag)
                    begin
                        phase_next         = PH_HUNT0;
                        header_count_next  = '0;
                        bytes_left_next    = '0;
                        first_pending_next = 1'b0;
                        res_valid          = 1'b1;
                        res.frame_first    = 1'b1;
                        res.frame_last     = 1'b1;
                        res.frame_status   = ST_TRUNCATED;
                    end
                    else
                    begin
                        header_count_next = header_count_reg + 3'd1;
                    end
                end
                else if (len_upd <= HDR_LEN || end_flag)
                begin
                    // Header done but no payload will follow in this buffer.
                    phase_next         = PH_HUNT0;
                    header_count_next  = '0;
                    bytes_left_next    = '0;
                    first_pending_next = 1'b0;
                    res_valid          = 1'b1;
                    res.frame_first    = 1'b1;
                    res.frame_last     = 1'b1;
                    if (len_upd < HDR_LEN)
                    begin
                        res.frame_status = ST_BAD_LEN;
                    end
                    else if (len_upd == HDR_LEN)
                    begin
                        res.frame_status = ST_EMPTY;
                    end
                    else
                    begin
                        res.frame_status   = ST_TRUNCATED;
                        res.payload_length = len_upd - HDR_LEN;
                    end
                end
                else
                begin
                    phase_next         = PH_PAYLOAD;
                    header_count_next  = '0;
                    bytes_left_next    = len_upd - HDR_LEN;
                    first_pending_next = 1'b1;
                end
            end
            PH_PAYLOAD:
            begin
                res_valid          = 1'b1;
                res.payload_byte   = b;
                res.frame_first    = first_pending_reg;
                res.payload_length = plen;
                res.frame_status   = ST_OK;
                first_pending_next = 1'b0;
                if (bytes_left_reg <= 13'd1 || end_flag)
                begin
                    phase_next        = PH_HUNT0;
                    header_count_next = '0;
                    bytes_left_next   = '0;
                    res.frame_last    = 1'b1;
                    if (bytes_left_reg > 13'd1)
                    begin
                        res.frame_status = ST_TRUNCATED;
                    end
                end
                else
                begin
                    bytes_left_next = bytes_left_reg - 13'd1;
                end
            end
            default:
            begin
                phase_next = PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_HUNT0;
            header_count_reg  <= '0;
            frame_length_reg  <= '0;
            bytes_left_reg    <= '0;
            first_pending_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            frame_length_reg  <= frame_length_next;
            bytes_left_reg    <= bytes_left_next;
            first_pending_reg <= first_pending_next;
        end
    end

endmodule

// ===== rtl/adts_out_reg.sv =====
// Result register: holds one finished word until the downstream side takes it.
module adts_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  adts_pkg::out_word_t load_word,
    output logic                busy,
    output logic                out_valid,
    input  logic                out_ready,
    output adts_pkg::out_word_t out_word
);
    import adts_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_word_t word_reg;

    assign out_valid = valid_reg;
    assign out_word  = word_reg;
    // Busy means a held word will still be here next cycle.
    assign busy      = valid_reg && !out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= load_word;
        end
    end

endmodule
